### rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned ResWidth     = 32;
  // products of two operands; magnitudes need one bit more than the operand pair
  localparam int unsigned MagWidth     = 2 * OperandWidth + 1;
  localparam int unsigned CntWidth     = $clog2(MagWidth + 1);

  typedef enum logic [2:0] {
    ModeAdd = 3'd0,
    ModeSub = 3'd1,
    ModeMul = 3'd2,
    ModeDiv = 3'd3,
    ModeGt  = 3'd4,
    ModeLt  = 3'd5
  } mode_e;

  typedef logic [OperandWidth-1:0] opnd_t;
  typedef logic [MagWidth-1:0]     mag_t;

  // divider handshake
  typedef struct packed {
    logic start;
    mag_t dividend;
    mag_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    mag_t quot;
    mag_t rem;
  } div_rsp_t;

endpackage

### rtl/rau_divider.sv
// Shared restoring divider: one quotient bit per cycle on unsigned magnitudes.
module rau_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::div_req_t req_i,
  output rau_pkg::div_rsp_t rsp_o
);
  import rau_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  mag_t            quot_q, quot_d;
  mag_t            rem_q, rem_d;
  mag_t            dvs_q, dvs_d;
  logic [MagWidth:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quot_q[MagWidth-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(MagWidth);
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = MagWidth'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[MagWidth-2:0], 1'b1};
      end else begin
        rem_d  = trial[MagWidth-1:0];
        quot_d = {quot_q[MagWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != '0)
    else $error("divider busy with zero count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy_q) |-> done_q)
    else $error("divider stopped without done");

endmodule

### rtl/rational_arithmetic_unit_core.sv
// Rational arithmetic unit: sequencer around combinational operand multipliers and a shared divider.
// Flow, accept to result valid: comparisons and errors go from the check state to output;
// multiply and divide reduce by one gcd; add/subtract first scale by the denominator gcd.
// Each divide is one start, one shift step per quotient bit, then a done strobe.
// Throughput: one word at a time; ready only while idle with no result pending.
// Reset: rst_ni asynchronous active low clears the sequencer and output valid.
module rational_arithmetic_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[2:0], a_num[18:3], a_den[34:19], b_num[50:35], b_den[66:51], zero pad
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // res_num[31:0], res_den[63:32], compare_true[64], error[65], zero pad
  output logic [71:0] m_axis_tdata
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StCheck, StGcd1, StScaleB, StScaleA, StCross, StLcm,
    StGcd2, StRedN, StRedD, StOut
  } state_e;

  state_e state_q;
  logic [2:0] mode_q;
  logic signed [OperandWidth-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [63:0] n_q, d_q;      // working numerator/denominator
  mag_t  ga_q, gb_q;                 // euclid pair
  mag_t  g_q;                        // gcd result
  logic  wait_q;
  logic  out_valid_q;
  logic [ResWidth-1:0] onum_q, oden_q;
  logic  ocmp_q, oerr_q;
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [2*OperandWidth-1:0] p1, p2, p3, p4;

  rau_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  function automatic mag_t mag64(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x[63] ? -x : x;
    return t[MagWidth-1:0];
  endfunction

  function automatic logic signed [63:0] sdiv(input logic signed [63:0] x, input mag_t q);
    logic signed [63:0] m;
    m = 64'(q);
    return x[63] ? -m : m;
  endfunction

  assign s_axis_tready = (state_q == StIdle) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, oerr_q, ocmp_q, oden_q, onum_q};

  // operand products, all fit the doubled operand width
  assign p1 = an_q * bd_q;
  assign p2 = bn_q * ad_q;
  assign p3 = an_q * bn_q;
  assign p4 = ad_q * bd_q;

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = ga_q;
    dreq.divisor  = gb_q;
    if (!wait_q) begin
      case (state_q)
        StGcd1, StGcd2: dreq.start = (gb_q != '0);
        StScaleB: begin
          dreq.start = 1'b1; dreq.dividend = mag64(64'(bd_q)); dreq.divisor = g_q;
        end
        StScaleA: begin
          dreq.start = 1'b1; dreq.dividend = mag64(64'(ad_q)); dreq.divisor = g_q;
        end
        StRedN:   begin dreq.start = 1'b1; dreq.dividend = mag64(n_q);  dreq.divisor = g_q; end
        StRedD:   begin dreq.start = 1'b1; dreq.dividend = mag64(d_q);  dreq.divisor = g_q; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      if (dreq.start) wait_q <= 1'b1;
      else if (drsp.done) wait_q <= 1'b0;
      case (state_q)
        StIdle: if (s_axis_tvalid && s_axis_tready) begin
          mode_q <= s_axis_tdata[2:0];
          an_q   <= signed'(s_axis_tdata[18:3]);
          ad_q   <= signed'(s_axis_tdata[34:19]);
          bn_q   <= signed'(s_axis_tdata[50:35]);
          bd_q   <= signed'(s_axis_tdata[66:51]);
          state_q <= StCheck;
        end
        StCheck: begin
          onum_q <= '0; oden_q <= '0; ocmp_q <= 1'b0; oerr_q <= 1'b0;
          if (mode_q > ModeLt) begin
            oerr_q <= 1'b1; state_q <= StOut;
          end else if (mode_q == ModeGt) begin
            ocmp_q <= (p1 > p2); state_q <= StOut;
          end else if (mode_q == ModeLt) begin
            ocmp_q <= (p1 < p2); state_q <= StOut;
          end else if (ad_q == 0 || bd_q == 0 || (mode_q == ModeDiv && bn_q == 0)) begin
            oerr_q <= 1'b1; state_q <= StOut;
          end else if (mode_q == ModeMul) begin
            n_q <= 64'(p3); d_q <= 64'(p4); state_q <= StCross;
          end else if (mode_q == ModeDiv) begin
            n_q <= 64'(p1); d_q <= 64'(p2); state_q <= StCross;
          end else begin
            ga_q <= mag64(64'(ad_q)); gb_q <= mag64(64'(bd_q)); state_q <= StGcd1;
          end
        end
        StGcd1, StGcd2: if (!wait_q) begin
          if (gb_q == '0) begin
            g_q <= (ga_q == '0) ? MagWidth'(1) : ga_q;
            state_q <= (state_q == StGcd1) ? StScaleB : StRedN;
          end
        end else if (drsp.done) begin
          ga_q <= gb_q; gb_q <= drsp.rem;
        end
        StScaleB: if (wait_q && drsp.done) begin
          bd_q <= OperandWidth'(sdiv(64'(bd_q), drsp.quot)); state_q <= StScaleA;
        end
        StScaleA: if (wait_q && drsp.done) begin
          // common denominator a_den * (b_den/g) while a_den is still whole
          d_q  <= 64'(p4);
          ad_q <= OperandWidth'(sdiv(64'(ad_q), drsp.quot)); state_q <= StLcm;
        end
        StLcm: begin
          // bd_q now b_den/g, ad_q a_den/g; p1 = an*bq, p2 = bn*aq
          n_q <= (mode_q == ModeAdd) ? 64'(p1) + 64'(p2) : 64'(p1) - 64'(p2);
          state_q <= StCross;
        end
        StCross: begin
          ga_q <= mag64(n_q); gb_q <= mag64(d_q); state_q <= StGcd2;
        end
        StRedN: if (wait_q && drsp.done) begin
          n_q <= sdiv(n_q, drsp.quot); state_q <= StRedD;
        end
        StRedD: if (wait_q && drsp.done) begin
          onum_q <= n_q[ResWidth-1:0];
          oden_q <= ResWidth'(sdiv(d_q, drsp.quot));
          state_q <= StOut;
        end
        StOut: if (!out_valid_q) begin
          out_valid_q <= 1'b1; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !out_valid_q)
    else $error("accepting while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_q) |-> $past(state_q) == StOut)
    else $error("result raised outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_q && oerr_q |-> !ocmp_q)
    else $error("error with compare flag");

endmodule
